// File: rtl/gas_hazard_level_classifier_top_macros.svh
// Assertion helpers used by the classifier top level.
`ifndef GAS_HAZARD_LEVEL_CLASSIFIER_TOP_MACROS_SVH
`define GAS_HAZARD_LEVEL_CLASSIFIER_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define GHL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define GHL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ghl_pkg.sv
package ghl_pkg;

  typedef struct packed {
    logic [23:0] co;
    logic [23:0] nh3;
    logic [23:0] no2;
    logic [23:0] voc;
  } src_t;

  typedef struct packed {
    src_t       scaled;
    logic [1:0] co_lvl;
    logic [1:0] nh3_lvl;
    logic [1:0] no2_lvl;
    logic [1:0] voc_lvl;
    logic [1:0] status;
  } res_t;

  localparam logic [1:0] LVL_ACCEPTABLE = 2'd0;
  localparam logic [1:0] LVL_ELEVATED   = 2'd1;
  localparam logic [1:0] LVL_DANGEROUS  = 2'd2;
  localparam logic [1:0] LVL_EMERGENCY  = 2'd3;

  localparam int SQRT_STEPS = 31;
  localparam int X_BITS     = 20;

  localparam logic [15:0] DECAY_LEN_RESET = 16'd256;

  // exp(-2^(j-16)) in Q.32, j = 0..19.
  localparam logic [31:0] EXP_TAB [X_BITS] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
    32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
    32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
    32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
  };

  // Q12.12 thresholds: acceptable/elevated/dangerous upper bounds.
  localparam logic [23:0] CO_T0  = 24'd36864;
  localparam logic [23:0] CO_T1  = 24'd143360;
  localparam logic [23:0] CO_T2  = 24'd819200;
  localparam logic [23:0] NH3_T0 = 24'd20480;
  localparam logic [23:0] NH3_T1 = 24'd102400;
  localparam logic [23:0] NH3_T2 = 24'd204800;
  localparam logic [23:0] NO2_T0 = 24'd409;
  localparam logic [23:0] NO2_T1 = 24'd4096;
  localparam logic [23:0] NO2_T2 = 24'd20480;
  localparam logic [23:0] VOC_T0 = 24'd204800;
  localparam logic [23:0] VOC_T1 = 24'd409600;
  localparam logic [23:0] VOC_T2 = 24'd819200;

  function automatic logic [1:0] classify(input logic [23:0] v, input logic [23:0] t0,
                                          input logic [23:0] t1, input logic [23:0] t2);
    logic [1:0] l;
    if (v <= t0) l = LVL_ACCEPTABLE;
    else if (v <= t1) l = LVL_ELEVATED;
    else if (v <= t2) l = LVL_DANGEROUS;
    else l = LVL_EMERGENCY;
    return l;
  endfunction

endpackage

// File: rtl/ghl_dist.sv
module ghl_dist (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  ghl_pkg::src_t      in_src,
  input  logic signed [23:0] hazard_x,
  input  logic signed [23:0] hazard_y,
  input  logic signed [23:0] hazard_z,
  input  logic signed [23:0] sensor_x,
  input  logic signed [23:0] sensor_y,
  input  logic signed [23:0] sensor_z,
  output logic               out_valid,
  output ghl_pkg::src_t      out_src,
  output logic [30:0]        out_d
);
  import ghl_pkg::*;

  logic signed [24:0] dx, dy, dz;
  logic [24:0] mx, my, mz;
  logic [49:0] sqx_nxt, sqy_nxt, sqz_nxt;
  logic [49:0] sqx_r, sqy_r, sqz_r;
  logic        sq_v_r;
  src_t        sq_src_r;

  logic [61:0] sn_r [0:SQRT_STEPS];
  logic [61:0] sr_r [0:SQRT_STEPS];
  logic        sv_r [0:SQRT_STEPS];
  src_t        ss_r [0:SQRT_STEPS];

  assign dx = 25'(sensor_x) - 25'(hazard_x);
  assign dy = 25'(sensor_y) - 25'(hazard_y);
  assign dz = 25'(sensor_z) - 25'(hazard_z);
  assign mx = dx[24] ? 25'(-dx) : 25'(dx);
  assign my = dy[24] ? 25'(-dy) : 25'(dy);
  assign mz = dz[24] ? 25'(-dz) : 25'(dz);
  assign sqx_nxt = 50'(mx) * 50'(mx);
  assign sqy_nxt = 50'(my) * 50'(my);
  assign sqz_nxt = 50'(mz) * 50'(mz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r <= in_valid;
      sv_r[0] <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r    <= sqx_nxt;
      sqy_r    <= sqy_nxt;
      sqz_r    <= sqz_nxt;
      sq_src_r <= in_src;
      sn_r[0]  <= {sqx_r + sqy_r + sqz_r, 12'b0};
      sr_r[0]  <= '0;
      ss_r[0]  <= sq_src_r;
    end
  end

  // One result bit of the integer square root per stage.
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (60 - 2 * i);
    logic [61:0] t;
    logic        ge;
    assign t  = sr_r[i] + BIT;
    assign ge = sn_r[i] >= t;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i+1] <= 1'b0;
      end else if (en) begin
        sv_r[i+1] <= sv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sn_r[i+1] <= ge ? sn_r[i] - t : sn_r[i];
        sr_r[i+1] <= ge ? (sr_r[i] >> 1) + BIT : sr_r[i] >> 1;
        ss_r[i+1] <= ss_r[i];
      end
    end
  end

  assign out_valid = sv_r[SQRT_STEPS];
  assign out_src   = ss_r[SQRT_STEPS];
  assign out_d     = sr_r[SQRT_STEPS][30:0];

endmodule

// File: rtl/ghl_div.sv
module ghl_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [15:0]   decay_len,
  input  logic          in_valid,
  input  ghl_pkg::src_t in_src,
  input  logic [30:0]   in_d,
  output logic          out_valid,
  output ghl_pkg::src_t out_src,
  output logic [19:0]   out_x,
  output logic          out_far
);
  import ghl_pkg::*;

  logic [15:0] len;
  logic [40:0] num;

  logic [35:0] rem_r [0:X_BITS];
  logic [19:0] q_r   [0:X_BITS];
  logic [15:0] len_r [0:X_BITS];
  logic        far_r [0:X_BITS];
  logic        v_r   [0:X_BITS];
  src_t        s_r   [0:X_BITS];

  // A zero length is taken as the smallest step.
  assign len = (decay_len == 16'd0) ? 16'd1 : decay_len;
  assign num = {in_d, 10'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  // When the quotient reaches 16.0 the factor is zero and the remainder path is unused.
  always_ff @(posedge clk) begin
    if (en) begin
      far_r[0] <= num >= {5'b0, len, 20'b0};
      rem_r[0] <= num[35:0];
      q_r[0]   <= '0;
      len_r[0] <= len;
      s_r[0]   <= in_src;
    end
  end

  for (genvar s = 0; s < X_BITS; s++) begin : g_div
    localparam int J = X_BITS - 1 - s;
    logic [35:0] sub;
    logic        ge;
    assign sub = 36'(len_r[s]) << J;
    assign ge  = rem_r[s] >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? rem_r[s] - sub : rem_r[s];
        q_r[s+1]   <= q_r[s] | (20'(ge) << J);
        len_r[s+1] <= len_r[s];
        far_r[s+1] <= far_r[s];
        s_r[s+1]   <= s_r[s];
      end
    end
  end

  assign out_valid = v_r[X_BITS];
  assign out_src   = s_r[X_BITS];
  assign out_x     = q_r[X_BITS];
  assign out_far   = far_r[X_BITS];

endmodule

// File: rtl/ghl_exp.sv
module ghl_exp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  ghl_pkg::src_t in_src,
  input  logic [19:0]   in_x,
  input  logic          in_far,
  output logic          out_valid,
  output ghl_pkg::src_t out_src,
  output logic [16:0]   out_k
);
  import ghl_pkg::*;

  // The accumulator is 1.0 until the first set bit, tracked by a flag.
  logic [31:0] acc_r [0:X_BITS];
  logic        one_r [0:X_BITS];
  logic [19:0] x_r   [0:X_BITS];
  logic        far_r [0:X_BITS];
  logic        v_r   [0:X_BITS];
  src_t        s_r   [0:X_BITS];

  logic [32:0] rnd;
  logic [16:0] k_nxt;
  logic [16:0] k_r;
  logic        kv_r;
  src_t        ks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r[0] <= '0;
      one_r[0] <= 1'b1;
      x_r[0]   <= in_x;
      far_r[0] <= in_far;
      s_r[0]   <= in_src;
    end
  end

  for (genvar j = 0; j < X_BITS; j++) begin : g_exp
    logic [63:0] prod;
    assign prod = 64'(acc_r[j]) * 64'(EXP_TAB[j]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (x_r[j][j]) begin
          acc_r[j+1] <= one_r[j] ? EXP_TAB[j] : prod[63:32];
          one_r[j+1] <= 1'b0;
        end else begin
          acc_r[j+1] <= acc_r[j];
          one_r[j+1] <= one_r[j];
        end
        x_r[j+1]   <= x_r[j];
        far_r[j+1] <= far_r[j];
        s_r[j+1]   <= s_r[j];
      end
    end
  end

  assign rnd = {1'b0, acc_r[X_BITS]} + 33'd32768;

  always_comb begin
    if (far_r[X_BITS]) k_nxt = '0;
    else if (one_r[X_BITS]) k_nxt = 17'h10000;
    else k_nxt = rnd[32:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kv_r <= 1'b0;
    end else if (en) begin
      kv_r <= v_r[X_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r  <= k_nxt;
      ks_r <= s_r[X_BITS];
    end
  end

  assign out_valid = kv_r;
  assign out_src   = ks_r;
  assign out_k     = k_r;

endmodule

// File: rtl/ghl_class.sv
module ghl_class (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  ghl_pkg::src_t in_src,
  input  logic [16:0]   in_k,
  output logic          out_valid,
  output ghl_pkg::res_t out_res
);
  import ghl_pkg::*;

  logic [40:0] p_co, p_nh3, p_no2, p_voc;
  src_t        sc_r;
  logic        sc_v_r;
  logic [1:0]  l_co, l_nh3, l_no2, l_voc, worst01, worst23, worst;
  logic [3:0]  score;
  res_t        res_nxt, res_r;
  logic        res_v_r;

  assign p_co  = 41'(in_src.co)  * 41'(in_k);
  assign p_nh3 = 41'(in_src.nh3) * 41'(in_k);
  assign p_no2 = 41'(in_src.no2) * 41'(in_k);
  assign p_voc = 41'(in_src.voc) * 41'(in_k);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else if (en) begin
      sc_v_r  <= in_valid;
      res_v_r <= sc_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r.co  <= p_co[39:16];
      sc_r.nh3 <= p_nh3[39:16];
      sc_r.no2 <= p_no2[39:16];
      sc_r.voc <= p_voc[39:16];
      res_r    <= res_nxt;
    end
  end

  assign l_co  = classify(sc_r.co,  CO_T0,  CO_T1,  CO_T2);
  assign l_nh3 = classify(sc_r.nh3, NH3_T0, NH3_T1, NH3_T2);
  assign l_no2 = classify(sc_r.no2, NO2_T0, NO2_T1, NO2_T2);
  assign l_voc = classify(sc_r.voc, VOC_T0, VOC_T1, VOC_T2);

  assign worst01 = (l_co > l_nh3) ? l_co : l_nh3;
  assign worst23 = (l_no2 > l_voc) ? l_no2 : l_voc;
  assign worst   = (worst01 > worst23) ? worst01 : worst23;
  assign score   = 4'(l_co) * 4'd3 + 4'(l_no2) * 4'd2 + 4'(l_nh3) + 4'(l_voc);

  always_comb begin
    res_nxt.scaled  = sc_r;
    res_nxt.co_lvl  = l_co;
    res_nxt.nh3_lvl = l_nh3;
    res_nxt.no2_lvl = l_no2;
    res_nxt.voc_lvl = l_voc;
    if (worst >= LVL_DANGEROUS) res_nxt.status = worst;
    else if (score <= 4'd2) res_nxt.status = LVL_ACCEPTABLE;
    else if (score <= 4'd5) res_nxt.status = LVL_ELEVATED;
    else res_nxt.status = LVL_DANGEROUS;
  end

  assign out_valid = res_v_r;
  assign out_res   = res_r;

endmodule

// File: rtl/gas_hazard_level_classifier_top.sv
// Channel   Handshake           Payload
// in        in_valid/in_stall   four source readings, hazard and sensor positions
// out       out_valid/out_stall four scaled readings, four levels, status
// cfg       cfg_wr_en           cfg_wr_data: decay length, unsigned Q8.8
//
// One item is accepted per cycle while in_stall is low. An accepted item passes through
// 33 registers for the squares, their sum and the 31-step square root, 21 for the
// divider, 22 for the decay multiplier chain and its rounding, 2 for scaling and
// classification, then the output register.
// Reset is synchronous and active low; decay length resets to 1.0 m.
// A two-entry output register and skid buffer hold results; the pipeline freezes,
// and in_stall rises, only while the skid entry is occupied.
module gas_hazard_level_classifier_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [23:0]        in_co_source,
  input  logic [23:0]        in_nh3_source,
  input  logic [23:0]        in_no2_source,
  input  logic [23:0]        in_voc_source,
  input  logic signed [23:0] in_hazard_x,
  input  logic signed [23:0] in_hazard_y,
  input  logic signed [23:0] in_hazard_z,
  input  logic signed [23:0] in_sensor_x,
  input  logic signed [23:0] in_sensor_y,
  input  logic signed [23:0] in_sensor_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [23:0]        out_co_scaled,
  output logic [23:0]        out_nh3_scaled,
  output logic [23:0]        out_no2_scaled,
  output logic [23:0]        out_voc_scaled,
  output logic [1:0]         out_co_level,
  output logic [1:0]         out_nh3_level,
  output logic [1:0]         out_no2_level,
  output logic [1:0]         out_voc_level,
  output logic [1:0]         out_status
);
  import ghl_pkg::*;
  `include "gas_hazard_level_classifier_top_macros.svh"

  logic [15:0] decay_len_r;
  logic        en;
  src_t        in_src;

  logic        d_v;
  src_t        d_src;
  logic [30:0] d_d;
  logic        x_v;
  src_t        x_src;
  logic [19:0] x_x;
  logic        x_far;
  logic        k_v;
  src_t        k_src;
  logic [16:0] k_k;
  logic        p_v;
  res_t        p_res;

  logic        out_valid_r, skid_full_r, out_fire;
  res_t        out_res_r, skid_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_len_r <= DECAY_LEN_RESET;
    end else if (cfg_wr_en) begin
      decay_len_r <= cfg_wr_data;
    end
  end

  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;
  assign in_src   = '{co: in_co_source, nh3: in_nh3_source,
                      no2: in_no2_source, voc: in_voc_source};

  ghl_dist u_dist (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid), .in_src(in_src),
    .hazard_x(in_hazard_x), .hazard_y(in_hazard_y), .hazard_z(in_hazard_z),
    .sensor_x(in_sensor_x), .sensor_y(in_sensor_y), .sensor_z(in_sensor_z),
    .out_valid(d_v), .out_src(d_src), .out_d(d_d)
  );

  ghl_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .decay_len(decay_len_r),
    .in_valid(d_v), .in_src(d_src), .in_d(d_d),
    .out_valid(x_v), .out_src(x_src), .out_x(x_x), .out_far(x_far)
  );

  ghl_exp u_exp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(x_v), .in_src(x_src), .in_x(x_x), .in_far(x_far),
    .out_valid(k_v), .out_src(k_src), .out_k(k_k)
  );

  ghl_class u_class (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(k_v), .in_src(k_src), .in_k(k_k),
    .out_valid(p_v), .out_res(p_res)
  );

  assign out_fire = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_fire) skid_full_r <= 1'b0;
    end else if (p_v) begin
      if (out_valid_r && out_stall) skid_full_r <= 1'b1;
      else out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_fire) out_res_r <= skid_res_r;
    end else if (p_v) begin
      if (out_valid_r && out_stall) skid_res_r <= p_res;
      else out_res_r <= p_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_co_scaled  = out_res_r.scaled.co;
  assign out_nh3_scaled = out_res_r.scaled.nh3;
  assign out_no2_scaled = out_res_r.scaled.no2;
  assign out_voc_scaled = out_res_r.scaled.voc;
  assign out_co_level   = out_res_r.co_lvl;
  assign out_nh3_level  = out_res_r.nh3_lvl;
  assign out_no2_level  = out_res_r.no2_lvl;
  assign out_voc_level  = out_res_r.voc_lvl;
  assign out_status     = out_res_r.status;

  `GHL_ASSERT_IMPL(a_skid_behind_out, skid_full_r, out_valid_r, "skid item without output item")
  `GHL_ASSERT_NEXT(a_skid_held, skid_full_r && out_stall, skid_full_r, "skid item lost")
  `GHL_ASSERT_IMPL(a_emerg_src, out_valid_r && out_status == LVL_EMERGENCY, out_co_level == LVL_EMERGENCY || out_nh3_level == LVL_EMERGENCY || out_no2_level == LVL_EMERGENCY || out_voc_level == LVL_EMERGENCY, "emergency status without emergency gas")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ghl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [23:0]        co;
    logic [23:0]        nh3;
    logic [23:0]        no2;
    logic [23:0]        voc;
    logic signed [23:0] hx;
    logic signed [23:0] hy;
    logic signed [23:0] hz;
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
  } gas_item_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [15:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [23:0]        in_co_source;
  logic [23:0]        in_nh3_source;
  logic [23:0]        in_no2_source;
  logic [23:0]        in_voc_source;
  logic signed [23:0] in_hazard_x;
  logic signed [23:0] in_hazard_y;
  logic signed [23:0] in_hazard_z;
  logic signed [23:0] in_sensor_x;
  logic signed [23:0] in_sensor_y;
  logic signed [23:0] in_sensor_z;
  logic               out_valid;
  logic               out_stall;
  logic [23:0]        out_co_scaled;
  logic [23:0]        out_nh3_scaled;
  logic [23:0]        out_no2_scaled;
  logic [23:0]        out_voc_scaled;
  logic [1:0]         out_co_level;
  logic [1:0]         out_nh3_level;
  logic [1:0]         out_no2_level;
  logic [1:0]         out_voc_level;
  logic [1:0]         out_status;

  gas_hazard_level_classifier_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_co_source   (in_co_source),
    .in_nh3_source  (in_nh3_source),
    .in_no2_source  (in_no2_source),
    .in_voc_source  (in_voc_source),
    .in_hazard_x    (in_hazard_x),
    .in_hazard_y    (in_hazard_y),
    .in_hazard_z    (in_hazard_z),
    .in_sensor_x    (in_sensor_x),
    .in_sensor_y    (in_sensor_y),
    .in_sensor_z    (in_sensor_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_co_scaled  (out_co_scaled),
    .out_nh3_scaled (out_nh3_scaled),
    .out_no2_scaled (out_no2_scaled),
    .out_voc_scaled (out_voc_scaled),
    .out_co_level   (out_co_level),
    .out_nh3_level  (out_nh3_level),
    .out_no2_level  (out_no2_level),
    .out_voc_level  (out_voc_level),
    .out_status     (out_status)
  );

  res_t        expected_levels[$];
  logic [15:0] decay_len_model;
  int          mismatch_count;
  int          cycle_count;
  bit          in_idle;
  bit          out_idle;
  bit          out_take;
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [1:0] gas_level(input logic [23:0] v, input logic [23:0] lo,
                                           input logic [23:0] mid, input logic [23:0] hi);
    if (v <= lo) return LVL_ACCEPTABLE;
    if (v <= mid) return LVL_ELEVATED;
    if (v <= hi) return LVL_DANGEROUS;
    return LVL_EMERGENCY;
  endfunction

  function automatic res_t predict_hazard(input gas_item_t it, input logic [15:0] len_reg);
    res_t        r;
    longint      dx, dy, dz;
    logic [63:0] dist_q14, len, x, acc, k;
    logic [1:0]  worst;
    logic [3:0]  score;
    dx = longint'(it.sx) - longint'(it.hx);
    dy = longint'(it.sy) - longint'(it.hy);
    dz = longint'(it.sz) - longint'(it.hz);
    dist_q14 = floor_sqrt(64'(dx * dx + dy * dy + dz * dz) << 12);
    len = (len_reg == 0) ? 64'd1 : 64'(len_reg);
    x = (dist_q14 << 10) / len;
    if (x >= 64'd1048576) begin
      k = 64'd0;
    end else begin
      acc = 64'd1 << 32;
      for (int j = 0; j < X_BITS; j++)
        if (x[j]) acc = (acc * 64'(EXP_TAB[j])) >> 32;
      k = (acc + 64'd32768) >> 16;
    end
    r.scaled.co  = 24'((64'(it.co) * k) >> 16);
    r.scaled.nh3 = 24'((64'(it.nh3) * k) >> 16);
    r.scaled.no2 = 24'((64'(it.no2) * k) >> 16);
    r.scaled.voc = 24'((64'(it.voc) * k) >> 16);
    r.co_lvl  = gas_level(r.scaled.co, CO_T0, CO_T1, CO_T2);
    r.nh3_lvl = gas_level(r.scaled.nh3, NH3_T0, NH3_T1, NH3_T2);
    r.no2_lvl = gas_level(r.scaled.no2, NO2_T0, NO2_T1, NO2_T2);
    r.voc_lvl = gas_level(r.scaled.voc, VOC_T0, VOC_T1, VOC_T2);
    worst = r.co_lvl;
    if (r.nh3_lvl > worst) worst = r.nh3_lvl;
    if (r.no2_lvl > worst) worst = r.no2_lvl;
    if (r.voc_lvl > worst) worst = r.voc_lvl;
    if (worst >= LVL_DANGEROUS) begin
      r.status = worst;
    end else begin
      score = 4'(r.co_lvl) * 4'd3 + 4'(r.no2_lvl) * 4'd2 + 4'(r.nh3_lvl) + 4'(r.voc_lvl);
      r.status = (score <= 4'd2) ? LVL_ACCEPTABLE : (score <= 4'd5) ? LVL_ELEVATED :
                 LVL_DANGEROUS;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [23:0] exp_v,
                               input logic [23:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0d, got %0d", field, exp_v, got_v);
  endtask

  // Results are checked on the falling edge before the rising edge that takes them.
  always @(negedge clk) begin
    res_t e;
    out_take = rst_n && out_valid && !out_stall;
    if (out_take) begin
      if (expected_levels.size() == 0) begin
        note_mismatch("unexpected item", 24'd0, 24'd0);
      end else begin
        e = expected_levels.pop_front();
        if (out_co_scaled !== e.scaled.co) note_mismatch("co_scaled", e.scaled.co, out_co_scaled);
        if (out_nh3_scaled !== e.scaled.nh3)
          note_mismatch("nh3_scaled", e.scaled.nh3, out_nh3_scaled);
        if (out_no2_scaled !== e.scaled.no2)
          note_mismatch("no2_scaled", e.scaled.no2, out_no2_scaled);
        if (out_voc_scaled !== e.scaled.voc)
          note_mismatch("voc_scaled", e.scaled.voc, out_voc_scaled);
        if (out_co_level !== e.co_lvl)
          note_mismatch("co_level", 24'(e.co_lvl), 24'(out_co_level));
        if (out_nh3_level !== e.nh3_lvl)
          note_mismatch("nh3_level", 24'(e.nh3_lvl), 24'(out_nh3_level));
        if (out_no2_level !== e.no2_lvl)
          note_mismatch("no2_level", 24'(e.no2_lvl), 24'(out_no2_level));
        if (out_voc_level !== e.voc_lvl)
          note_mismatch("voc_level", 24'(e.voc_lvl), 24'(out_voc_level));
        if (out_status !== e.status)
          note_mismatch("status", 24'(e.status), 24'(out_status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (out_take) stall_left = out_idle ? $urandom_range(0, 14) : 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d items outstanding", expected_levels.size());
      $display("** gas_hazard_level_classifier_top: FAILED **");
      $finish;
    end
  end

  task automatic send_reading(input gas_item_t it);
    int gap;
    in_co_source  <= it.co;
    in_nh3_source <= it.nh3;
    in_no2_source <= it.no2;
    in_voc_source <= it.voc;
    in_hazard_x   <= it.hx;
    in_hazard_y   <= it.hy;
    in_hazard_z   <= it.hz;
    in_sensor_x   <= it.sx;
    in_sensor_y   <= it.sy;
    in_sensor_z   <= it.sz;
    in_valid      <= 1'b1;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    expected_levels.push_back(predict_hazard(it, decay_len_model));
    gap = in_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lowers valid and lets the pipeline empty so the register can change.
  task automatic drain_pipeline;
    in_valid <= 1'b0;
    while (expected_levels.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_decay_length(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    decay_len_model = v;
    @(posedge clk);
  endtask

  function automatic gas_item_t at_source(input logic [23:0] co, input logic [23:0] nh3,
                                          input logic [23:0] no2, input logic [23:0] voc);
    gas_item_t it;
    it.co = co; it.nh3 = nh3; it.no2 = no2; it.voc = voc;
    it.hx = '0; it.hy = '0; it.hz = '0; it.sx = '0; it.sy = '0; it.sz = '0;
    return it;
  endfunction

  function automatic logic [23:0] rand_reading;
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 1000000));
      2: return 24'($urandom_range(0, 30000));
      default: return 24'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic logic signed [23:0] near_to(input logic signed [23:0] p);
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return p + 24'($signed(17'($urandom)));
      2: return p + 24'($signed(11'($urandom)));
      default: return p;
    endcase
  endfunction

  function automatic gas_item_t rand_item;
    gas_item_t it;
    it.co = rand_reading(); it.nh3 = rand_reading();
    it.no2 = rand_reading(); it.voc = rand_reading();
    it.hx = 24'($urandom); it.hy = 24'($urandom); it.hz = 24'($urandom);
    it.sx = near_to(it.hx); it.sy = near_to(it.hy); it.sz = near_to(it.hz);
    return it;
  endfunction

  task automatic test_thresholds;
    gas_item_t it;
    in_idle = 0;
    out_idle = 0;
    send_reading(at_source(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_reading(at_source(24'd0, 24'd0, 24'd0, 24'd0));
    send_reading(at_source(CO_T0, NH3_T0, NO2_T0, VOC_T0));
    send_reading(at_source(CO_T0 + 24'd1, 24'd0, 24'd0, 24'd0));
    send_reading(at_source(24'd0, NH3_T0 + 24'd1, 24'd0, 24'd0));
    send_reading(at_source(24'd0, 24'd0, NO2_T0 + 24'd1, 24'd0));
    send_reading(at_source(24'd0, 24'd0, 24'd0, VOC_T0 + 24'd1));
    send_reading(at_source(CO_T0 + 24'd1, NH3_T0 + 24'd1, NO2_T0 + 24'd1, VOC_T0 + 24'd1));
    send_reading(at_source(24'd0, NH3_T0 + 24'd1, NO2_T0 + 24'd1, 24'd0));
    send_reading(at_source(CO_T1, NH3_T1, NO2_T1, VOC_T1));
    send_reading(at_source(CO_T1 + 24'd1, 24'd0, 24'd0, 24'd0));
    send_reading(at_source(CO_T2, NH3_T2, NO2_T2, VOC_T2));
    send_reading(at_source(24'd0, NH3_T2 + 24'd1, 24'd0, 24'd0));
    send_reading(at_source(24'd0, 24'd0, 24'd0, VOC_T2 + 24'd1));
    // A hazard at the far corner of the space drives the decay factor to zero.
    it = at_source(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    it.hx = 24'sh800000; it.hy = 24'sh800000; it.hz = 24'sh800000;
    it.sx = 24'sh7FFFFF; it.sy = 24'sh7FFFFF; it.sz = 24'sh7FFFFF;
    send_reading(it);
    it.hx = 24'sh7FFFFF; it.hy = 24'sh7FFFFF; it.hz = 24'sh7FFFFF;
    it.sx = 24'sh800000; it.sy = 24'sh800000; it.sz = 24'sh800000;
    send_reading(it);
    it = at_source(24'h800000, 24'h400000, 24'h200000, 24'h100000);
    it.hx = 24'sh000100; it.sy = -24'sh000080; it.sz = 24'sh000040;
    send_reading(it);
    drain_pipeline();
  endtask

  task automatic test_decay_lengths;
    logic [15:0] lens[4];
    gas_item_t   it;
    lens = '{16'd0, 16'd1, 16'hFFFF, DECAY_LEN_RESET};
    foreach (lens[i]) begin
      write_decay_length(lens[i]);
      for (int n = 0; n < 4; n++) begin
        it = at_source(24'hFFFFFF, 24'h0FFFFF, 24'h00FFFF, 24'h7FFFFF);
        it.sx = 24'(n * 64);
        it.sy = -24'(n * 300);
        send_reading(it);
      end
      drain_pipeline();
    end
  endtask

  task automatic test_random_traffic;
    logic [15:0] len;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: len = 16'd1;
        1: len = 16'hFFFF;
        2: len = DECAY_LEN_RESET;
        default: len = 16'($urandom);
      endcase
      write_decay_length(len);
      for (int n = 0; n < 100; n++) begin
        if (n % 25 == 0) begin
          in_idle = $urandom_range(0, 2) != 0;
          out_idle = $urandom_range(0, 2) != 0;
        end
        send_reading(rand_item());
      end
      drain_pipeline();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_co_source = '0;
    in_nh3_source = '0;
    in_no2_source = '0;
    in_voc_source = '0;
    in_hazard_x = '0;
    in_hazard_y = '0;
    in_hazard_z = '0;
    in_sensor_x = '0;
    in_sensor_y = '0;
    in_sensor_z = '0;
    decay_len_model = DECAY_LEN_RESET;
    mismatch_count = 0;
    cycle_count = 0;
    in_idle = 0;
    out_idle = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_thresholds();
    test_decay_lengths();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("** gas_hazard_level_classifier_top: PASSED **");
    end else begin
      $display("** gas_hazard_level_classifier_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ghl_pkg.sv
rtl/ghl_dist.sv
rtl/ghl_div.sv
rtl/ghl_exp.sv
rtl/ghl_class.sv
rtl/gas_hazard_level_classifier_top.sv
test/tb_top.sv
